// ===== hw/rtl/calendar_date_day_offset_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the calendar date day offset block
// Implication checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DAY_OFFSET_ASSERT_SVH
`define CALENDAR_DATE_DAY_OFFSET_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar date assertion failed");
// Next-cycle implication.
`define CDO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar date assertion failed");
`else
`define CDO_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CDO_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/cdo_pkg.sv =====
// ----------------------------------------------------------------------------
// cdo_pkg
// Types, codes and calendar helpers shared by the date offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdo_pkg;

    localparam int NumMonths = 12;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_ADD  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [4:0] DAYS_MAX      = 5'd31;

    // Reset date: 1 January 2000. 2000 is a multiple of 25.
    localparam logic [4:0]  RST_DAY   = 5'd1;
    localparam logic [3:0]  RST_MONTH = 4'd1;
    localparam logic [13:0] RST_YEAR  = 14'd2000;
    localparam logic [4:0]  RST_M25   = 5'd0;

    // Reciprocal of 25 scaled by 2^17; exact quotient for any 14-bit year.
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam int          RecipShift = 17;
    localparam logic [4:0]  M25_TOP = 5'd24;

    localparam logic [4:0] MONTH_LEN [NumMonths] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic               opcode;
        logic [4:0]         new_day;
        logic [3:0]         new_month;
        logic [13:0]        new_year;
        logic signed [15:0] day_offset;
    } t_in;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic [1:0]  status;
    } t_out;

    typedef struct packed {
        logic       cap;
        logic       ld_mul;
        logic       ld_mod;
        logic       ld_commit;
        logic       walk_step;
        logic       walk_commit;
        logic       set_status;
        logic [1:0] status;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic in_add;
        logic ld_ok;
        logic walk_zero;
        logic walk_range;
    } t_sts;

    // Leap year from the year's low four bits and its remainder modulo 25:
    // a multiple of 100 is a multiple of 4 and 25, one of 400 of 16 and 25.
    function automatic logic is_leap(logic [3:0] yr_lo, logic [4:0] m25);
        logic d4;
        logic d16;
        logic d25;
        d4  = (yr_lo[1:0] == 2'd0);
        d16 = (yr_lo == 4'd0);
        d25 = (m25 == 5'd0);
        return (d4 && !d25) || (d16 && d25);
    endfunction

    // Length of a month; a code outside 1 to 12 reads as 31.
    function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
        logic [4:0] len;
        len = DAYS_MAX;
        if (month == MON_FEB && leap) begin
            len = DAYS_FEB_LEAP;
        end else if (month >= MON_JAN && month <= MON_DEC) begin
            len = MONTH_LEN[4'(month - MON_JAN)];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cdo_dp.sv =====
// ----------------------------------------------------------------------------
// cdo_dp
// Datapath: stored date, load check, month-by-month walk and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_dp #(
    parameter int MAX_YEAR = 9999
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cdo_pkg::t_in  i_in,
    input  cdo_pkg::t_cmd i_cmd,
    output cdo_pkg::t_sts o_sts,
    output cdo_pkg::t_out o_out
);
    import cdo_pkg::*;

    localparam logic [13:0] MaxYr = 14'(MAX_YEAR);

    // Stored date and its year modulo 25.
    logic [4:0]  r_cur_day;
    logic [3:0]  r_cur_mon;
    logic [13:0] r_cur_yr;
    logic [4:0]  r_cur_m25;

    // Load candidate.
    logic [4:0]  r_ld_day;
    logic [3:0]  r_ld_mon;
    logic [13:0] r_ld_yr;
    logic [9:0]  r_ld_q;
    logic [4:0]  r_ld_m25;

    // Walk copy and remaining offset.
    logic [4:0]         r_w_day, n_w_day;
    logic [3:0]         r_w_mon, n_w_mon;
    logic [13:0]        r_w_yr, n_w_yr;
    logic [4:0]         r_w_m25, n_w_m25;
    logic signed [16:0] r_w_d, n_w_d;

    logic [1:0] r_status;
    t_out       r_out;

    logic               w_leap;
    logic [4:0]         dim_cur;
    logic [4:0]         dim_prev;
    logic signed [16:0] left;
    logic signed [16:0] sum_b;
    logic               fwd_fits;
    logic               back_fits;
    logic               ld_leap;
    logic [13:0]        q_x25;

    assign w_leap    = is_leap(r_w_yr[3:0], r_w_m25);
    assign dim_cur   = days_in(r_w_mon, w_leap);
    assign dim_prev  = days_in(4'(r_w_mon - 4'd1), w_leap);
    assign left      = $signed({12'd0, dim_cur}) - $signed({12'd0, r_w_day});
    assign sum_b     = r_w_d + $signed({12'd0, r_w_day});
    assign fwd_fits  = (r_w_d <= left);
    assign back_fits = (sum_b > 17'sd0);

    assign ld_leap = is_leap(r_ld_yr[3:0], r_ld_m25);
    assign q_x25   = 14'({r_ld_q, 4'd0}) + 14'({r_ld_q, 3'd0}) + 14'(r_ld_q);

    always_comb begin
        o_sts.in_add     = (i_in.opcode == OP_ADD);
        o_sts.ld_ok      = (r_ld_mon >= MON_JAN) && (r_ld_mon <= MON_DEC)
                           && (r_ld_yr <= MaxYr) && (r_ld_day != 5'd0)
                           && (r_ld_day <= days_in(r_ld_mon, ld_leap));
        o_sts.walk_zero  = (r_w_d == 17'sd0);
        o_sts.walk_range = ((r_w_d > 17'sd0) && !fwd_fits && (r_w_mon == MON_DEC)
                            && (r_w_yr >= MaxYr))
                           || ((r_w_d < 17'sd0) && !back_fits && (r_w_mon == MON_JAN)
                            && (r_w_yr == 14'd0));
    end

    // One month of the walk.
    always_comb begin
        n_w_day = r_w_day;
        n_w_mon = r_w_mon;
        n_w_yr  = r_w_yr;
        n_w_m25 = r_w_m25;
        n_w_d   = r_w_d;
        if (r_w_d > 17'sd0) begin
            if (fwd_fits) begin
                n_w_day = r_w_day + r_w_d[4:0];
                n_w_d   = 17'sd0;
            end else begin
                n_w_d   = r_w_d - left - 17'sd1;
                n_w_day = 5'd1;
                if (r_w_mon == MON_DEC) begin
                    n_w_mon = MON_JAN;
                    n_w_yr  = r_w_yr + 14'd1;
                    n_w_m25 = (r_w_m25 == M25_TOP) ? 5'd0 : r_w_m25 + 5'd1;
                end else begin
                    n_w_mon = r_w_mon + 4'd1;
                end
            end
        end else if (r_w_d < 17'sd0) begin
            if (back_fits) begin
                n_w_day = sum_b[4:0];
                n_w_d   = 17'sd0;
            end else begin
                n_w_d = sum_b;
                if (r_w_mon == MON_JAN) begin
                    n_w_day = DAYS_MAX;
                    n_w_mon = MON_DEC;
                    n_w_yr  = r_w_yr - 14'd1;
                    n_w_m25 = (r_w_m25 == 5'd0) ? M25_TOP : r_w_m25 - 5'd1;
                end else begin
                    n_w_day = dim_prev;
                    n_w_mon = r_w_mon - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day <= RST_DAY;
            r_cur_mon <= RST_MONTH;
            r_cur_yr  <= RST_YEAR;
            r_cur_m25 <= RST_M25;
        end else if (i_cmd.ld_commit) begin
            r_cur_day <= r_ld_day;
            r_cur_mon <= r_ld_mon;
            r_cur_yr  <= r_ld_yr;
            r_cur_m25 <= r_ld_m25;
        end else if (i_cmd.walk_commit) begin
            r_cur_day <= r_w_day;
            r_cur_mon <= r_w_mon;
            r_cur_yr  <= r_w_yr;
            r_cur_m25 <= r_w_m25;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_ld_day <= i_in.new_day;
            r_ld_mon <= i_in.new_month;
            r_ld_yr  <= i_in.new_year;
            r_w_day  <= r_cur_day;
            r_w_mon  <= r_cur_mon;
            r_w_yr   <= r_cur_yr;
            r_w_m25  <= r_cur_m25;
            r_w_d    <= {i_in.day_offset[15], i_in.day_offset};
        end else if (i_cmd.walk_step) begin
            r_w_day <= n_w_day;
            r_w_mon <= n_w_mon;
            r_w_yr  <= n_w_yr;
            r_w_m25 <= n_w_m25;
            r_w_d   <= n_w_d;
        end
        if (i_cmd.ld_mul) begin
            r_ld_q <= 10'((27'(r_ld_yr) * 27'(RECIP25)) >> RecipShift);
        end
        if (i_cmd.ld_mod) begin
            r_ld_m25 <= 5'(r_ld_yr - q_x25);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.emit) begin
            r_out.out_day   <= r_cur_day;
            r_out.out_month <= r_cur_mon;
            r_out.out_year  <= r_cur_yr;
            r_out.status    <= r_status;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/cdo_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdo_ctrl
// Controller: sequences load checks and month walks, owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cdo_pkg::t_sts i_sts,
    output cdo_pkg::t_cmd o_cmd
);
    import cdo_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LD_MUL = 6'b000010,
        S_LD_MOD = 6'b000100,
        S_LD_CHK = 6'b001000,
        S_WALK   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_o_valid, n_o_valid;
    logic   out_free;

    assign out_free    = !r_o_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;

    always_comb begin
        n_state   = r_state;
        n_o_valid = r_o_valid && !i_out_ready;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = i_sts.in_add ? S_WALK : S_LD_MUL;
                end
            end
            S_LD_MUL: begin
                o_cmd.ld_mul = 1'b1;
                n_state      = S_LD_MOD;
            end
            S_LD_MOD: begin
                o_cmd.ld_mod = 1'b1;
                n_state      = S_LD_CHK;
            end
            S_LD_CHK: begin
                o_cmd.ld_commit  = i_sts.ld_ok;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = i_sts.ld_ok ? ST_OK : ST_BAD_DATE;
                n_state          = S_EMIT;
            end
            S_WALK: begin
                if (i_sts.walk_range) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_RANGE;
                    n_state          = S_EMIT;
                end else if (i_sts.walk_zero) begin
                    o_cmd.walk_commit = 1'b1;
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status      = ST_OK;
                    n_state           = S_EMIT;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_o_valid  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_date_day_offset.sv =====
// ----------------------------------------------------------------------------
// calendar_date_day_offset
// Gregorian date register with checked load and signed day offset.
// ----------------------------------------------------------------------------
// The block holds one date. Items arrive on the input channel (i_in_valid,
// o_in_ready, i_in) and each one yields exactly one item on the output
// channel (o_out_valid, i_out_ready, o_out) carrying the stored date after
// the item and a status: ok, invalid date rejected, or year range exceeded.
// A load item finds the remainder modulo 25 of the new year by a reciprocal
// multiply (S_LD_MUL) and a subtraction (S_LD_MOD); the check and commit
// follow in S_LD_CHK, and the result register loads in S_EMIT once it is free.
// An add item walks the calendar one month per cycle in the datapath; a
// full 16-bit offset crosses up to roughly 1080 months.
// One item is in flight at a time: the input is ready only while the
// controller is idle. The finished result sits in an output register, so
// the next item is accepted while an earlier result still waits; a new
// result waits in the controller until that register has been taken.
// Reset (synchronous, active low) sets the date to 1 January 2000 and
// empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_date_day_offset_assert.svh"

module calendar_date_day_offset #(
    parameter int MAX_YEAR = 9999
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cdo_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cdo_pkg::t_out o_out
);
    import cdo_pkg::*;

    // Command and status groups between controller and datapath.
    t_cmd cmd;
    t_sts sts;

    cdo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cdo_dp #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

    // An accepted item keeps the input closed for at least the next cycle.
    `CDO_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // A delivered date always has a real month and a nonzero day.
    `CDO_ASSERT_IMP(a_out_date_sane, i_clk, i_rst_n, o_out_valid,
        (o_out.out_month >= MON_JAN) && (o_out.out_month <= MON_DEC)
        && (o_out.out_day != 5'd0))

    // The status is one of the three defined codes.
    `CDO_ASSERT_IMP(a_out_status_code, i_clk, i_rst_n, o_out_valid,
        (o_out.status == ST_OK) || (o_out.status == ST_BAD_DATE)
        || (o_out.status == ST_RANGE))

endmodule

`default_nettype wire
